@@ rtl/ledf_pkg.sv @@
// Shared types and constants for the six-channel LED fader.
// No dependencies; imported by ledf_channel and six_channel_led_fader.
package ledf_pkg;

  // Field widths fixed by the stream format
  localparam int unsigned ReqW      = 2;
  localparam int unsigned LevelW    = 8;
  localparam int unsigned DutyW     = 9;
  localparam int unsigned OfsW      = 4;
  localparam int unsigned ChanSelW  = 4;

  // Level fields carried on the input stream, duty fields on the output
  localparam int unsigned LevelFields = 6;

  // Packed stream widths, padded to whole bytes
  localparam int unsigned InDataW  = 56;  // 6 levels + channel select = 52 bits
  localparam int unsigned OutDataW = 64;  // 6 duties + fading + level = 63 bits

  localparam int unsigned ChannelsDefault = 6;
  localparam logic [OfsW-1:0] OfsReset = 4'd2;

  // Request kinds
  typedef enum logic [ReqW-1:0] {
    REQ_FADE   = 2'd0,
    REQ_DIRECT = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_READ   = 2'd3
  } req_e;

  // Per-channel control from the top level
  typedef struct packed {
    logic en;   // request processed this cycle
    req_e req;
  } chan_ctrl_t;

endpackage

@@ rtl/ledf_channel.sv @@
// One fader channel: target and current compare value with step logic.
// Depends on ledf_pkg.
module ledf_channel (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ledf_pkg::chan_ctrl_t         ctrl_i,
  input  logic [ledf_pkg::LevelW-1:0]  level_i,
  input  logic [ledf_pkg::OfsW-1:0]    min_offset_i,
  output logic [ledf_pkg::DutyW-1:0]   target_o,
  output logic [ledf_pkg::DutyW-1:0]   current_d_o,
  output logic                         moved_o
);
  import ledf_pkg::*;

  logic [DutyW-1:0] target_q, target_d;
  logic [DutyW-1:0] current_q, current_d;
  logic [DutyW-1:0] mapped;

  // Zero stays off, anything else gets the anti-flicker offset
  assign mapped = (level_i == '0) ? '0
                : DutyW'({1'b0, level_i} + {{(DutyW-OfsW){1'b0}}, min_offset_i});

  // Next state per request kind
  always_comb begin
    target_d  = target_q;
    current_d = current_q;
    if (ctrl_i.en) begin
      case (ctrl_i.req)
        REQ_FADE: begin
          target_d = mapped;
        end
        REQ_DIRECT: begin
          target_d  = mapped;
          current_d = mapped;
        end
        REQ_TICK: begin
          if (target_q > current_q) begin
            current_d = current_q + DutyW'(1);
          end else if (target_q < current_q) begin
            current_d = current_q - DutyW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q  <= '0;
      current_q <= '0;
    end else begin
      target_q  <= target_d;
      current_q <= current_d;
    end
  end

  assign target_o    = target_q;
  assign current_d_o = current_d;
  assign moved_o     = (target_q != current_q);

  // A direct set lands current on target
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.en && ctrl_i.req == REQ_DIRECT |=> current_q == target_q)
    else $error("direct set left current off target");

  // A fade set never touches the current value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.en && ctrl_i.req == REQ_FADE |=> $stable(current_q))
    else $error("fade set moved current value");

  // A tick moves by one step at most
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.en && ctrl_i.req == REQ_TICK |=>
      (current_q == $past(current_q)) ||
      (current_q == $past(current_q) + DutyW'(1)) ||
      (current_q == $past(current_q) - DutyW'(1)))
    else $error("tick stepped by more than one");

endmodule

@@ rtl/six_channel_led_fader.sv @@
// Six-channel LED fader: input register, channel update, result register.
// Each accepted word passes through the input register, then the result register.
// Throughput: one word per cycle; the input and result registers each
// hold one word and move together whenever the result side is free.
// Reset clears all targets, current values and the fading flag, and
// loads the offset register with 2. Depends on ledf_pkg, ledf_channel.
module six_channel_led_fader #(
  parameter int unsigned CHANNELS = ledf_pkg::ChannelsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ledf_pkg::OfsW-1:0]      cfg_data_i,    // min_offset
  // request stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // level_1[7:0] .. level_6[47:40], read_channel[51:48], zero pad
  input  logic [ledf_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic [ledf_pkg::ReqW-1:0]      s_axis_tuser,  // req_type
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // duty_1[8:0] .. duty_6[53:45], fading[54], level_read[62:55], zero pad
  output logic [ledf_pkg::OutDataW-1:0]  m_axis_tdata
);
  import ledf_pkg::*;

  localparam int unsigned LevelsTop = LevelFields * LevelW;

  logic [OfsW-1:0]     min_offset_q;
  logic                in_valid_q, in_valid_d;
  req_e                req_q;
  logic [LevelW-1:0]   level_q [LevelFields];
  logic [ChanSelW-1:0] read_ch_q;

  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic                moved_q, moved_d;
  logic                s_accept, advance;
  chan_ctrl_t          ctrl;

  logic [LevelW-1:0]   ch_level   [CHANNELS];
  logic [DutyW-1:0]    ch_target  [CHANNELS];
  logic [DutyW-1:0]    ch_cur_d   [CHANNELS];
  logic [CHANNELS-1:0] ch_moved;
  logic [DutyW-1:0]    duty_w     [LevelFields];

  logic [DutyW-1:0]    sel_target;
  logic [DutyW-1:0]    diff;
  logic [LevelW-1:0]   level_read;

  // Configuration: always ready; write only while idle (the block does not enforce this)
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_offset_q <= OfsReset;
    end else if (cfg_valid_i) begin
      min_offset_q <= cfg_data_i;
    end
  end

  // Handshake: stage moves when the result register is empty or drained
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign in_valid_d  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      moved_q     <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      moved_q     <= moved_d;
    end
  end

  // Input word register
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      req_q     <= req_e'(s_axis_tuser);
      read_ch_q <= s_axis_tdata[LevelsTop +: ChanSelW];
      for (int i = 0; i < LevelFields; i++) begin
        level_q[i] <= s_axis_tdata[i*LevelW +: LevelW];
      end
    end
  end

  assign ctrl.en  = advance;
  assign ctrl.req = req_q;

  // Channels; those beyond the level fields always see level 0
  for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
    if (i < LevelFields) begin : g_lvl
      assign ch_level[i] = level_q[i];
    end else begin : g_nolvl
      assign ch_level[i] = '0;
    end

    ledf_channel u_chan (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .level_i      (ch_level[i]),
      .min_offset_i (min_offset_q),
      .target_o     (ch_target[i]),
      .current_d_o  (ch_cur_d[i]),
      .moved_o      (ch_moved[i])
    );
  end

  // Only a tick rewrites the fading flag
  assign moved_d = (advance && req_q == REQ_TICK) ? (|ch_moved) : moved_q;

  // Read select: one compare per channel, out-of-range gives zero
  always_comb begin
    sel_target = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if ({1'b0, read_ch_q} == (ChanSelW+1)'(i + 1)) begin
        sel_target = ch_target[i];
      end
    end
  end

  // Target minus offset, saturated to a level
  assign diff = sel_target - {{(DutyW-OfsW){1'b0}}, min_offset_q};

  always_comb begin
    level_read = '0;
    if (req_q == REQ_READ && sel_target > {{(DutyW-OfsW){1'b0}}, min_offset_q}) begin
      level_read = diff[DutyW-1] ? '1 : diff[LevelW-1:0];
    end
  end

  // Duty fields for channels that exist, zero otherwise
  for (genvar j = 0; j < LevelFields; j++) begin : g_duty
    if (j < CHANNELS) begin : g_on
      assign duty_w[j] = ch_cur_d[j];
    end else begin : g_off
      assign duty_w[j] = '0;
    end
  end

  // Result word packing
  always_comb begin
    out_data_d = '0;
    for (int j = 0; j < LevelFields; j++) begin
      out_data_d[j*DutyW +: DutyW] = duty_w[j];
    end
    out_data_d[LevelFields*DutyW]                 = moved_d;
    out_data_d[LevelFields*DutyW + 1 +: LevelW]   = level_read;
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Accepted word is held in the input register next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> in_valid_q)
    else $error("accepted word not captured");

  // Processing a word always produces a result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid)
    else $error("processed word without result");

  // Fading flag changes only on a tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && req_q == REQ_TICK) |=> moved_q == $past(moved_q))
    else $error("fading flag changed outside a tick");

endmodule

@@ sim/fader_checker.sv @@
// Checker for the six-channel LED fader: watches the config, request and result channels,
// predicts every result word and compares it field by field with the DUT output.
// Depends on ledf_pkg.
module fader_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [ledf_pkg::OfsW-1:0]      cfg_data_i,
  input  logic                           req_tvalid_i,
  input  logic                           req_tready_i,
  // level_1 .. level_6, read_channel, pad
  input  logic [ledf_pkg::InDataW-1:0]   req_tdata_i,
  input  logic [ledf_pkg::ReqW-1:0]      req_tuser_i,   // req_type
  input  logic                           res_tvalid_i,
  input  logic                           res_tready_i,
  // duty_1 .. duty_6, fading, level_read, pad
  input  logic [ledf_pkg::OutDataW-1:0]  res_tdata_i,
  output int                             fail_count_o,
  output int                             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ledf_pkg::*;

  localparam int unsigned MaxReports = 10;

  // Result word layout, lowest field last
  typedef struct packed {
    logic                                 pad;
    logic [LevelW-1:0]                    level_read;
    logic                                 fading;
    logic [LevelFields-1:0][DutyW-1:0]    duty;
  } fader_result_t;

  // Local copy of the fader state
  logic [OfsW-1:0]   min_offset;
  logic [DutyW-1:0]  target_duty [LevelFields];
  logic [DutyW-1:0]  current_duty [LevelFields];
  logic              moved;
  fader_result_t     expected_q [$];
  int                result_idx;

  // Zero stays off, anything else gets the anti-flicker offset
  function automatic logic [DutyW-1:0] level_to_duty(logic [LevelW-1:0] lv);
    logic [DutyW-1:0] d;
    d = DutyW'(lv);
    if (lv != '0) d = d + DutyW'(min_offset);
    return d;
  endfunction

  // Target minus offset, clamped to a byte; bad channel or dark target reads 0
  function automatic logic [LevelW-1:0] level_of(logic [ChanSelW-1:0] ch);
    logic [DutyW-1:0] t;
    if (ch < 1 || ch > LevelFields) return '0;
    t = target_duty[ch - 1];
    if (t == '0 || t <= DutyW'(min_offset)) return '0;
    t = t - DutyW'(min_offset);
    return (t > 255) ? '1 : t[LevelW-1:0];
  endfunction

  // Update state for one request and build the result word it produces
  task automatic apply_request(input req_e req, input logic [InDataW-1:0] data,
                               output fader_result_t res);
    res = '0;
    case (req)
      REQ_FADE, REQ_DIRECT: begin
        for (int i = 0; i < LevelFields; i++) begin
          target_duty[i] = level_to_duty(data[i*LevelW +: LevelW]);
          if (req == REQ_DIRECT) current_duty[i] = target_duty[i];
        end
      end
      REQ_TICK: begin
        moved = 1'b0;
        for (int i = 0; i < LevelFields; i++) begin
          if (target_duty[i] != current_duty[i]) begin
            if (target_duty[i] > current_duty[i]) current_duty[i] = current_duty[i] + 1'b1;
            else current_duty[i] = current_duty[i] - 1'b1;
            moved = 1'b1;
          end
        end
      end
      default: begin
        res.level_read = level_of(data[LevelFields*LevelW +: ChanSelW]);
      end
    endcase
    for (int i = 0; i < LevelFields; i++) res.duty[i] = current_duty[i];
    res.fading = moved;
  endtask

  task automatic report_failure(input string msg);
    fail_count_o++;
    if (fail_count_o <= MaxReports) $display("%t: %s", $realtime, msg);
  endtask

  // Compare outgoing words first, then predict the incoming one
  always @(posedge clk_i or negedge rst_ni) begin : watch
    fader_result_t got_r;
    fader_result_t exp_r;
    fader_result_t pred_r;
    logic          bad;
    if (!rst_ni) begin
      min_offset = OfsReset;
      for (int i = 0; i < LevelFields; i++) begin
        target_duty[i]  = '0;
        current_duty[i] = '0;
      end
      moved = 1'b0;
      expected_q.delete();
      result_idx = 0;
    end else begin
      if (res_tvalid_i && res_tready_i) begin
        got_r = res_tdata_i;
        if (expected_q.size() == 0) begin
          report_failure($sformatf("result word %0d arrived with nothing expected: %h",
                                   result_idx, res_tdata_i));
        end else begin
          exp_r = expected_q.pop_front();
          bad = 1'b0;
          for (int i = 0; i < LevelFields; i++)
            if (got_r.duty[i] !== exp_r.duty[i]) bad = 1'b1;
          if (got_r.fading !== exp_r.fading) bad = 1'b1;
          if (got_r.level_read !== exp_r.level_read) bad = 1'b1;
          if (bad)
            report_failure($sformatf({"result word %0d mismatch: expected duty=%h fading=%b ",
                                      "level=%0d, got duty=%h fading=%b level=%0d"},
                                     result_idx, exp_r.duty, exp_r.fading, exp_r.level_read,
                                     got_r.duty, got_r.fading, got_r.level_read));
        end
        result_idx++;
      end
      if (cfg_valid_i && cfg_ready_i) min_offset = cfg_data_i;
      if (req_tvalid_i && req_tready_i) begin
        apply_request(req_e'(req_tuser_i), req_tdata_i, pred_r);
        expected_q.push_back(pred_r);
      end
    end
    pending_o = expected_q.size();
  end

endmodule

@@ sim/tb_top.sv @@
// Testbench top for six_channel_led_fader: drives requests, config writes and result
// back-pressure, and prints the verdict. Depends on ledf_pkg and fader_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ledf_pkg::*;

  localparam int unsigned LevelBits     = LevelFields * LevelW;
  localparam int          RandomItems   = 500;
  localparam int          RandomPhases  = 6;
  localparam int          HoldCycles    = 64;
  localparam int          WatchdogLimit = 3000;

  logic                  clk_i;
  logic                  rst_ni     = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [OfsW-1:0]       cfg_data   = OfsReset;
  logic                  req_tvalid = 1'b0;
  logic                  req_tready;
  logic [InDataW-1:0]    req_tdata  = '0;      // level_1 .. level_6, read_channel, pad
  logic [ReqW-1:0]       req_tuser  = REQ_FADE; // req_type
  logic                  res_tvalid;
  logic                  res_tready = 1'b0;
  logic [OutDataW-1:0]   res_tdata;            // duty_1 .. duty_6, fading, level_read, pad

  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  logic hold_go     = 1'b0;
  int   fail_count;
  int   pending;
  int   stall_cycles = 0;

  six_channel_led_fader dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .s_axis_tvalid(req_tvalid),
    .s_axis_tready(req_tready),
    .s_axis_tdata (req_tdata),
    .s_axis_tuser (req_tuser),
    .m_axis_tvalid(res_tvalid),
    .m_axis_tready(res_tready),
    .m_axis_tdata (res_tdata)
  );

  fader_checker u_fader_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .req_tvalid_i(req_tvalid),
    .req_tready_i(req_tready),
    .req_tdata_i (req_tdata),
    .req_tuser_i (req_tuser),
    .res_tvalid_i(res_tvalid),
    .res_tready_i(res_tready),
    .res_tdata_i (res_tdata),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Result sink: random back-pressure, plus one long hold when asked
  initial begin : result_sink
    int   hold_left;
    logic hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        res_tready <= 1'b0;
        hold_left--;
      end else if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HoldCycles - 1;
        res_tready <= 1'b0;
      end else begin
        res_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog: too long without any word moving ends the run
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_tvalid && req_tready) || (res_tvalid && res_tready) || (cfg_valid && cfg_ready))
        stall_cycles <= 0;
      else if (stall_cycles >= WatchdogLimit) begin
        $display("FAILURE");
        $finish;
      end else
        stall_cycles <= stall_cycles + 1;
    end
  end

  // One request word; levels are packed channel 1 in the lowest byte
  task automatic send_request(input req_e req, input logic [LevelBits-1:0] levels,
                              input logic [ChanSelW-1:0] ch);
    logic [InDataW-1:0] word;
    word = '0;
    word[0 +: LevelBits] = levels;
    word[LevelBits +: ChanSelW] = ch;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      req_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    req_tvalid <= 1'b1;
    req_tuser  <= req;
    req_tdata  <= word;
    @(posedge clk_i);
    while (!req_tready) @(posedge clk_i);
  endtask

  // Stop offering and wait for every outstanding result word
  task automatic wait_drained();
    req_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Offset register write; only called with the block drained
  task automatic write_offset(input logic [OfsW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Levels lean toward off, minimum, maximum and small steps
  function automatic logic [LevelW-1:0] rand_level();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 8'd1;
      3, 4:    return LevelW'($urandom_range(0, 8));
      default: return LevelW'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random();
    logic [LevelBits-1:0] levels;
    logic [ChanSelW-1:0]  ch;
    int                   pick;
    req_e                 req;
    for (int i = 0; i < LevelFields; i++) levels[i*LevelW +: LevelW] = rand_level();
    if ($urandom_range(0, 4) == 0) ch = ChanSelW'($urandom_range(0, 15));
    else ch = ChanSelW'($urandom_range(1, LevelFields));
    pick = $urandom_range(0, 99);
    if (pick < 20) req = REQ_FADE;
    else if (pick < 35) req = REQ_DIRECT;
    else if (pick < 75) req = REQ_TICK;
    else req = REQ_READ;
    send_request(req, levels, ch);
  endtask

  // Stimulus and verdict
  initial begin : stimulus
    logic [OfsW-1:0] ofs;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, reset offset of 2; levels listed channel 6 down to 1
    send_request(REQ_READ, '0, 4'd1);                  // dark channel reads 0
    send_request(REQ_TICK, '0, 4'd0);                  // nothing to move
    send_request(REQ_DIRECT, {8'd1, 8'd255, 8'd128, 8'd0, 8'd1, 8'd255}, 4'd0);
    for (int c = 1; c <= LevelFields; c++)
      send_request(REQ_READ, '0, ChanSelW'(c));
    send_request(REQ_READ, '1, 4'd0);                  // channel 0 is invalid
    send_request(REQ_READ, '1, 4'd7);                  // just past the last channel
    send_request(REQ_READ, '1, 4'd15);
    send_request(REQ_FADE, {8'd0, 8'd2, 8'd1, 8'd255, 8'd3, 8'd0}, 4'd15);
    send_request(REQ_TICK, '1, 4'd3);
    send_request(REQ_TICK, '0, 4'd0);
    send_request(REQ_READ, '0, 4'd4);
    send_request(REQ_FADE, '0, 4'd0);                  // everything off
    send_request(REQ_TICK, '1, 4'd15);
    wait_drained();

    // Largest target, then offset dropped: read saturates at 255
    write_offset(4'd15);
    send_request(REQ_DIRECT, '1, 4'd0);
    send_request(REQ_TICK, '0, 4'd0);
    wait_drained();
    write_offset(4'd0);
    send_request(REQ_READ, '0, 4'd1);
    wait_drained();

    // Small target, then offset raised above it: read gives 0
    send_request(REQ_DIRECT, {6{8'd1}}, 4'd0);
    wait_drained();
    write_offset(4'd15);
    send_request(REQ_READ, '0, 4'd1);
    send_request(REQ_READ, '0, 4'd6);
    wait_drained();

    // Random phases: sender-light/receiver-heavy idling, then swapped, then none
    for (int phase = 0; phase < RandomPhases; phase++) begin
      case (phase / 2)
        0: begin tx_idle_pct = 32; rx_idle_pct <= 88; end
        1: begin tx_idle_pct = 88; rx_idle_pct <= 32; end
        default: begin tx_idle_pct = 0; rx_idle_pct <= 0; end
      endcase
      case (phase)
        0:       ofs = '1;
        1:       ofs = '0;
        2:       ofs = OfsReset;
        default: ofs = OfsW'($urandom_range(0, 15));
      endcase
      write_offset(ofs);
      if (phase == 4) hold_go <= 1'b1;  // long result stall with full-rate requests
      repeat (RandomItems / RandomPhases) send_random();
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
